### hdl/ebf_pkg.sv
package ebf_pkg;

  // One input beat.
  typedef struct packed {
    logic signed [31:0] node_a_x;
    logic signed [31:0] node_a_y;
    logic signed [31:0] node_b_x;
    logic signed [31:0] node_b_y;
    logic signed [31:0] cell_density;
    logic signed [31:0] cell_momentum_x;
    logic signed [31:0] cell_momentum_y;
    logic signed [31:0] cell_energy;
    logic [30:0]        step_factor;
    logic               boundary_kind;
  } ebf_in_t;

  // One result beat.
  typedef struct packed {
    logic signed [31:0] delta_mass;
    logic signed [31:0] delta_momentum_x;
    logic signed [31:0] delta_momentum_y;
    logic signed [31:0] delta_energy;
    logic               bad_density;
  } ebf_out_t;

  // Configuration register file.
  typedef struct packed {
    logic [30:0]        gamma_m1;
    logic [30:0]        eps;
    logic [30:0]        free_rho;
    logic signed [31:0] free_mx;
    logic signed [31:0] free_my;
    logic signed [31:0] free_en;
  } ebf_cfg_t;

  // Edge data carried alongside the arithmetic.
  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] rho;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] en;
    logic [30:0]        stepf;
    logic               wall;
    logic               bad;
  } ebf_item_t;

  typedef enum logic [2:0] {
    CFG_GAMMA_M1 = 3'd0,
    CFG_EPS      = 3'd1,
    CFG_FREE_RHO = 3'd2,
    CFG_FREE_MX  = 3'd3,
    CFG_FREE_MY  = 3'd4,
    CFG_FREE_EN  = 3'd5
  } ebf_cfg_e;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  // Clamp a wide value to the 32 bit signed range.
  function automatic logic signed [31:0] sat_wide(input logic signed [63:0] v);
    if (v > 64'sh000000007fffffff) return SAT_MAX;
    if (v < 64'shffffffff80000000) return SAT_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return sat_wide(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] s;
    s = 64'(a) - 64'(b);
    return sat_wide(s);
  endfunction

  function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
    logic signed [63:0] s;
    s = 64'sd0 - 64'(a);
    return sat_wide(s);
  endfunction

endpackage

### hdl/ebf_recip.sv
// Two-lane pipelined reciprocal: 2^(2*FRAC_BITS) / d, one quotient bit per stage.
module ebf_recip import ebf_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int PW        = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [1:0][31:0]  den_i,
  input  logic [PW-1:0]            pay_i,
  output logic                     valid_o,
  output logic signed [1:0][31:0]  quo_o,
  output logic [PW-1:0]            pay_o
);

  localparam int QW = 2 * FRAC_BITS + 1;
  // The quotient register is never narrower than 33 bits, so the overflow
  // check above bit 30 always has bits to look at.
  localparam int QB = (QW > 33) ? QW : 33;

  logic [31:0]   rem_q [QW][2];
  logic [31:0]   den_q [QW][2];
  logic [QB-1:0] quo_q [QW][2];
  logic          pos_q [QW][2];
  logic          vld_q [QW];
  logic [PW-1:0] pay_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [31:0]   rem_in [2];
    logic [31:0]   den_in [2];
    logic [QB-1:0] quo_in [2];
    logic          pos_in [2];
    logic          vld_in;
    logic [PW-1:0] pay_in;

    // Stage inputs come from the ports for the first stage, else from the one before.
    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          rem_in[l] = '0;
          den_in[l] = den_i[l];
          quo_in[l] = '0;
          pos_in[l] = ($signed(den_i[l]) > 32'sd0);
        end
        vld_in = valid_i;
        pay_in = pay_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          rem_in[l] = rem_q[s-1][l];
          den_in[l] = den_q[s-1][l];
          quo_in[l] = quo_q[s-1][l];
          pos_in[l] = pos_q[s-1][l];
        end
        vld_in = vld_q[s-1];
        pay_in = pay_q[s-1];
      end
    end

    // Restoring step: shift in the next dividend bit, subtract when it fits.
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 2; l++) begin
        logic [32:0]   t;
        logic [QB-1:0] q;
        t = {rem_in[l], (s == 0)};
        q = quo_in[l];
        den_q[s][l] <= den_in[l];
        pos_q[s][l] <= pos_in[l];
        if (t >= {1'b0, den_in[l]}) begin
          rem_q[s][l] <= 32'(t - {1'b0, den_in[l]});
          q[QW-1-s]    = 1'b1;
        end else begin
          rem_q[s][l] <= t[31:0];
        end
        quo_q[s][l] <= q;
      end
      pay_q[s] <= pay_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end
  end

  // Saturate the quotient; a non-positive divisor reads as the largest value.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!pos_q[QW-1][l] || (|quo_q[QW-1][l][QB-1:31])) begin
        quo_o[l] = SAT_MAX;
      end else begin
        quo_o[l] = $signed({1'b0, quo_q[QW-1][l][30:0]});
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign pay_o   = pay_q[QW-1];

endmodule

### hdl/ebf_flux.sv
// Eight-stage flux pipeline after the reciprocals, at most one multiply level per stage.
module ebf_flux import ebf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ebf_item_t          item_i,
  input  logic signed [31:0] inv_c_i,
  input  logic signed [31:0] inv_f_i,
  input  ebf_cfg_t           cfg_i,
  output logic               valid_o,
  output ebf_out_t           res_o
);

  // Product shifted down toward minus infinity, then saturated.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat_wide(p >>> FRAC_BITS);
  endfunction

  logic signed [31:0] gm, eps, rinf;
  assign gm   = $signed({1'b0, cfg_i.gamma_m1});
  assign eps  = $signed({1'b0, cfg_i.eps});
  assign rinf = $signed({1'b0, cfg_i.free_rho});

  logic      vld_q [8];
  ebf_item_t it_q  [7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < 8; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    it_q[0] <= item_i;
    for (int i = 1; i < 7; i++) it_q[i] <= it_q[i-1];
  end

  // Stage 1: squares, cross products, damping factor and state differences.
  logic signed [31:0] mxx1_q, myy1_q, fxx1_q, fyy1_q;
  logic signed [31:0] mxey1_q, myex1_q, fmxey1_q, fmyex1_q;
  logic signed [31:0] damp1_q, dr1_q, dmx1_q, dmy1_q, de1_q, invc1_q, invf1_q;
  always_ff @(posedge clk_i) begin
    mxx1_q   <= fx_mul(item_i.mx, item_i.mx);
    myy1_q   <= fx_mul(item_i.my, item_i.my);
    fxx1_q   <= fx_mul(cfg_i.free_mx, cfg_i.free_mx);
    fyy1_q   <= fx_mul(cfg_i.free_my, cfg_i.free_my);
    mxey1_q  <= fx_mul(item_i.mx, item_i.ey);
    myex1_q  <= fx_mul(item_i.my, item_i.ex);
    fmxey1_q <= fx_mul(cfg_i.free_mx, item_i.ey);
    fmyex1_q <= fx_mul(cfg_i.free_my, item_i.ex);
    damp1_q  <= fx_mul($signed({1'b0, item_i.stepf}), eps);
    dr1_q    <= sat_sub(item_i.rho, rinf);
    dmx1_q   <= sat_sub(item_i.mx, cfg_i.free_mx);
    dmy1_q   <= sat_sub(item_i.my, cfg_i.free_my);
    de1_q    <= sat_sub(item_i.en, cfg_i.free_en);
    invc1_q  <= inv_c_i;
    invf1_q  <= inv_f_i;
  end

  // Stage 2: momentum magnitudes, normal momenta and dissipation terms.
  logic signed [31:0] m2c2_q, m2f2_q, nc2_q, nf2_q, invc2_q, invf2_q;
  logic signed [31:0] tm2_q [4];
  always_ff @(posedge clk_i) begin
    m2c2_q   <= sat_add(mxx1_q, myy1_q);
    m2f2_q   <= sat_add(fxx1_q, fyy1_q);
    nc2_q    <= sat_sub(mxey1_q, myex1_q);
    nf2_q    <= sat_sub(fmxey1_q, fmyex1_q);
    tm2_q[0] <= fx_mul(damp1_q, dr1_q);
    tm2_q[1] <= fx_mul(damp1_q, dmx1_q);
    tm2_q[2] <= fx_mul(damp1_q, dmy1_q);
    tm2_q[3] <= fx_mul(damp1_q, de1_q);
    invc2_q  <= invc1_q;
    invf2_q  <= invf1_q;
  end

  // Stage 3: kinetic terms and normal velocities.
  logic signed [31:0] kc3_q, kf3_q, vc3_q, vf3_q;
  logic signed [31:0] tm3_q [4];
  always_ff @(posedge clk_i) begin
    kc3_q <= fx_mul(invc2_q, m2c2_q);
    kf3_q <= fx_mul(invf2_q, m2f2_q);
    vc3_q <= fx_mul(invc2_q, nc2_q);
    vf3_q <= fx_mul(invf2_q, nf2_q);
    tm3_q <= tm2_q;
  end

  // Stage 4: internal energies and the convective products.
  logic signed [31:0] ec4_q, ef4_q, vc4_q, vf4_q;
  logic signed [31:0] vcr4_q, vfr4_q, vcx4_q, vfx4_q, vcy4_q, vfy4_q;
  logic signed [31:0] tm4_q [4];
  always_ff @(posedge clk_i) begin
    ec4_q  <= sat_sub(it_q[2].en, kc3_q >>> 1);
    ef4_q  <= sat_sub(cfg_i.free_en, kf3_q >>> 1);
    vcr4_q <= fx_mul(vc3_q, it_q[2].rho);
    vfr4_q <= fx_mul(vf3_q, rinf);
    vcx4_q <= fx_mul(vc3_q, it_q[2].mx);
    vfx4_q <= fx_mul(vf3_q, cfg_i.free_mx);
    vcy4_q <= fx_mul(vc3_q, it_q[2].my);
    vfy4_q <= fx_mul(vf3_q, cfg_i.free_my);
    vc4_q  <= vc3_q;
    vf4_q  <= vf3_q;
    tm4_q  <= tm3_q;
  end

  // Stage 5: pressures.
  logic signed [31:0] pc5_q, pf5_q, vc5_q, vf5_q;
  logic signed [31:0] vcr5_q, vfr5_q, vcx5_q, vfx5_q, vcy5_q, vfy5_q;
  logic signed [31:0] tm5_q [4];
  always_ff @(posedge clk_i) begin
    pc5_q  <= fx_mul(gm, ec4_q);
    pf5_q  <= fx_mul(gm, ef4_q);
    vc5_q  <= vc4_q;
    vf5_q  <= vf4_q;
    vcr5_q <= vcr4_q;
    vfr5_q <= vfr4_q;
    vcx5_q <= vcx4_q;
    vfx5_q <= vfx4_q;
    vcy5_q <= vcy4_q;
    vfy5_q <= vfy4_q;
    tm5_q  <= tm4_q;
  end

  // Stage 6: pressure forces and total enthalpies.
  logic signed [31:0] pcey6_q, pcex6_q, pfey6_q, pfex6_q, hc6_q, hf6_q, vc6_q, vf6_q;
  logic signed [31:0] vcr6_q, vfr6_q, vcx6_q, vfx6_q, vcy6_q, vfy6_q;
  logic signed [31:0] tm6_q [4];
  always_ff @(posedge clk_i) begin
    pcey6_q <= fx_mul(pc5_q, it_q[4].ey);
    pcex6_q <= fx_mul(pc5_q, it_q[4].ex);
    pfey6_q <= fx_mul(pf5_q, it_q[4].ey);
    pfex6_q <= fx_mul(pf5_q, it_q[4].ex);
    hc6_q   <= sat_add(it_q[4].en, pc5_q);
    hf6_q   <= sat_add(cfg_i.free_en, pf5_q);
    vc6_q   <= vc5_q;
    vf6_q   <= vf5_q;
    vcr6_q  <= vcr5_q;
    vfr6_q  <= vfr5_q;
    vcx6_q  <= vcx5_q;
    vfx6_q  <= vfx5_q;
    vcy6_q  <= vcy5_q;
    vfy6_q  <= vfy5_q;
    tm6_q   <= tm5_q;
  end

  // Stage 7: energy fluxes and the mass and momentum sums.
  logic signed [31:0] ea7_q, eb7_q, s0_7_q, s1_7_q, s2_7_q, pcey7_q, pcex7_q;
  logic signed [31:0] tm7_q [4];
  always_ff @(posedge clk_i) begin
    ea7_q   <= fx_mul(vc6_q, hc6_q);
    eb7_q   <= fx_mul(vf6_q, hf6_q);
    s0_7_q  <= sat_add(vcr6_q, vfr6_q);
    s1_7_q  <= sat_add(sat_add(sat_add(vcx6_q, pcey6_q), vfx6_q), pfey6_q);
    s2_7_q  <= sat_sub(sat_add(sat_sub(vcy6_q, pcex6_q), vfy6_q), pfex6_q);
    pcey7_q <= pcey6_q;
    pcex7_q <= pcex6_q;
    tm7_q   <= tm6_q;
  end

  // Stage 8: halve, add dissipation, and select by the bad-density flag, then boundary kind.
  ebf_out_t res_d, res_q;
  always_comb begin
    res_d = '0;
    if (it_q[6].bad) begin
      res_d.bad_density = 1'b1;
    end else if (it_q[6].wall) begin
      res_d.delta_momentum_x = pcey7_q;
      res_d.delta_momentum_y = sat_neg(pcex7_q);
    end else begin
      res_d.delta_mass       = sat_add(s0_7_q >>> 1, tm7_q[0]);
      res_d.delta_momentum_x = sat_add(s1_7_q >>> 1, tm7_q[1]);
      res_d.delta_momentum_y = sat_add(s2_7_q >>> 1, tm7_q[2]);
      res_d.delta_energy     = sat_add(sat_add(ea7_q, eb7_q) >>> 1, tm7_q[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = vld_q[7];
  assign res_o   = res_q;

endmodule

### hdl/euler_boundary_flux_top.sv
// Boundary edge residual increment for a 2D Euler solver, signed fixed point with
// FRAC_BITS fraction bits. The block takes one edge per clock and busy is never
// raised. Each result appears on res_o with done_o high for exactly one cycle,
// after its start beat has passed through the reciprocal pipeline, which resolves
// one quotient bit per stage, and then eight stages of flux arithmetic. The
// receiver cannot hold results off, so it must take every beat as it comes.
// Configuration writes are registered and must only happen while no edge is in
// flight.
module euler_boundary_flux_top import ebf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ebf_in_t     in_i,
  output logic        done_o,
  output ebf_out_t    res_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int IW = $bits(ebf_item_t);

  // Configuration registers.
  ebf_cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gamma_m1 <= 31'd26214;
      cfg_q.eps      <= 31'd3277;
      cfg_q.free_rho <= 31'd91750;
      cfg_q.free_mx  <= 32'sd36700;
      cfg_q.free_my  <= 32'sd0;
      cfg_q.free_en  <= 32'sd171187;
    end else if (cfg_we_i) begin
      unique case (ebf_cfg_e'(cfg_idx_i))
        CFG_GAMMA_M1: cfg_q.gamma_m1 <= cfg_wdata_i[30:0];
        CFG_EPS:      cfg_q.eps      <= cfg_wdata_i[30:0];
        CFG_FREE_RHO: cfg_q.free_rho <= cfg_wdata_i[30:0];
        CFG_FREE_MX:  cfg_q.free_mx  <= $signed(cfg_wdata_i);
        CFG_FREE_MY:  cfg_q.free_my  <= $signed(cfg_wdata_i);
        CFG_FREE_EN:  cfg_q.free_en  <= $signed(cfg_wdata_i);
        default:      ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Edge vector and the fields that ride along with the reciprocals.
  ebf_item_t item;
  always_comb begin
    item.ex    = sat_sub(in_i.node_a_x, in_i.node_b_x);
    item.ey    = sat_sub(in_i.node_a_y, in_i.node_b_y);
    item.rho   = in_i.cell_density;
    item.mx    = in_i.cell_momentum_x;
    item.my    = in_i.cell_momentum_y;
    item.en    = in_i.cell_energy;
    item.stepf = in_i.step_factor;
    item.wall  = in_i.boundary_kind;
    item.bad   = (in_i.cell_density <= 32'sd0);
  end

  logic signed [1:0][31:0] den, quo;
  logic [IW-1:0]           pay;
  logic                    rcp_vld;
  ebf_item_t               rcp_item;

  assign den[0] = in_i.cell_density;
  assign den[1] = $signed({1'b0, cfg_q.free_rho});

  ebf_recip #(
    .FRAC_BITS(FRAC_BITS),
    .PW       (IW)
  ) u_recip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start & ~busy),
    .den_i  (den),
    .pay_i  (item),
    .valid_o(rcp_vld),
    .quo_o  (quo),
    .pay_o  (pay)
  );

  assign rcp_item = ebf_item_t'(pay);

  ebf_flux #(
    .FRAC_BITS(FRAC_BITS)
  ) u_flux (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(rcp_vld),
    .item_i (rcp_item),
    .inv_c_i(quo[0]),
    .inv_f_i(quo[1]),
    .cfg_i  (cfg_q),
    .valid_o(done_o),
    .res_o  (res_o)
  );

endmodule
